FILE: rtl/one_wire_bus_master_assert.svh
// assertion macros for the one-wire bus master checker
// no dependencies
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("one-wire master check failed");

// next-cycle implication, disabled during reset
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("one-wire master check failed");

`endif

FILE: rtl/owm_pkg.sv
// shared types and constants of the one-wire bus master
// no dependencies
package owm_pkg;

    localparam int REG_W = 10;
    localparam int CFG_IDX_W = 3;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_TICK  = 2'd0;
    localparam t_mode MODE_RESET = 2'd1;
    localparam t_mode MODE_WRITE = 2'd2;
    localparam t_mode MODE_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_REC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ONE_LOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW      = 3'd5;

    localparam logic [REG_W-1:0] RESET_LOW_DEF     = 10'd480;
    localparam logic [REG_W-1:0] PRESENCE_WAIT_DEF = 10'd80;
    localparam logic [REG_W-1:0] RESET_REC_DEF     = 10'd400;
    localparam logic [REG_W-1:0] WRITE_ONE_LOW_DEF = 10'd1;
    localparam logic [REG_W-1:0] SLOT_DEF          = 10'd60;
    localparam logic [REG_W-1:0] READ_LOW_DEF      = 10'd2;

    typedef struct packed {
        logic [REG_W-1:0] reset_low_us;
        logic [REG_W-1:0] presence_wait_us;
        logic [REG_W-1:0] reset_recovery_us;
        logic [REG_W-1:0] write_one_low_us;
        logic [REG_W-1:0] slot_us;
        logic [REG_W-1:0] read_low_us;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] data_byte;
        logic       line_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       device_present;
        logic [7:0] read_byte;
        logic       refused;
    } t_out_item;

endpackage

FILE: rtl/owm_stream_if.sv
// valid/ready stream channel carrying one payload per transaction
// payload type is set at instantiation, usually from owm_pkg
interface owm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/owm_cfg.sv
// configuration register file of the one-wire bus master
// depends on owm_pkg
module owm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [owm_pkg::REG_W-1:0]        i_wdata,
    output owm_pkg::t_cfg                    o_cfg
);
    import owm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                CFG_RESET_LOW:     n_cfg.reset_low_us      = i_wdata;
                CFG_PRESENCE_WAIT: n_cfg.presence_wait_us  = i_wdata;
                CFG_RESET_REC:     n_cfg.reset_recovery_us = i_wdata;
                CFG_WRITE_ONE_LOW: n_cfg.write_one_low_us  = i_wdata;
                CFG_SLOT:          n_cfg.slot_us           = i_wdata;
                CFG_READ_LOW:      n_cfg.read_low_us       = i_wdata;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_us      <= RESET_LOW_DEF;
            r_cfg.presence_wait_us  <= PRESENCE_WAIT_DEF;
            r_cfg.reset_recovery_us <= RESET_REC_DEF;
            r_cfg.write_one_low_us  <= WRITE_ONE_LOW_DEF;
            r_cfg.slot_us           <= SLOT_DEF;
            r_cfg.read_low_us       <= READ_LOW_DEF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/owm_core.sv
// bus sequencer: phase state, tick timer, bit counter and shift register
// depends on owm_pkg; result is combinational from the next state
module owm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  owm_pkg::t_in_item   i_item,
    input  owm_pkg::t_cfg       i_cfg,
    output owm_pkg::t_out_item  o_res
);
    import owm_pkg::*;

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_REC  = 4'd3;
    localparam logic [3:0] PH_W1_LOW   = 4'd4;
    localparam logic [3:0] PH_W1_REL   = 4'd5;
    localparam logic [3:0] PH_W0_LOW   = 4'd6;
    localparam logic [3:0] PH_R_LOW    = 4'd7;
    localparam logic [3:0] PH_R_SAMPLE = 4'd8;
    localparam logic [3:0] PH_R_SLOT   = 4'd9;

    logic [3:0]       r_phase,    n_phase;
    logic [REG_W-1:0] r_timer,    n_timer;
    logic [2:0]       r_bit,      n_bit;
    logic [7:0]       r_shift,    n_shift;
    logic             r_presence, n_presence;
    logic [7:0]       r_rx,       n_rx;

    logic [REG_W:0]   tick_count;
    logic [REG_W-1:0] phase_len;
    logic [2:0]       bit_inc;
    logic             done;
    logic             refused;

    function automatic logic [REG_W-1:0] at_least_one(input logic [REG_W-1:0] v);
        at_least_one = (v == '0) ? {{(REG_W-1){1'b0}}, 1'b1} : v;
    endfunction

    always_comb begin
        unique case (r_phase) inside
            PH_RST_LOW:                   phase_len = at_least_one(i_cfg.reset_low_us);
            PH_RST_WAIT:                  phase_len = at_least_one(i_cfg.presence_wait_us);
            PH_RST_REC:                   phase_len = at_least_one(i_cfg.reset_recovery_us);
            PH_W1_LOW:                    phase_len = at_least_one(i_cfg.write_one_low_us);
            PH_W1_REL, PH_W0_LOW, PH_R_SLOT: phase_len = at_least_one(i_cfg.slot_us);
            PH_R_LOW:                     phase_len = at_least_one(i_cfg.read_low_us);
            default:                      phase_len = {{(REG_W-1){1'b0}}, 1'b1};
        endcase
    end

    assign tick_count = {1'b0, r_timer} + {{REG_W{1'b0}}, 1'b1};
    assign bit_inc    = r_bit + 3'd1;

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_presence = r_presence;
        n_rx       = r_rx;
        done       = 1'b0;
        refused    = 1'b0;
        if (i_fire) begin
            if (i_item.mode != MODE_TICK) begin
                if (r_phase != PH_IDLE) begin
                    refused = 1'b1;
                end else begin
                    n_timer = '0;
                    unique case (i_item.mode)
                        MODE_RESET: n_phase = PH_RST_LOW;
                        MODE_WRITE: begin
                            n_shift = i_item.data_byte;
                            n_bit   = 3'd0;
                            n_phase = i_item.data_byte[0] ? PH_W1_LOW : PH_W0_LOW;
                        end
                        MODE_READ: begin
                            n_shift = 8'd0;
                            n_bit   = 3'd0;
                            n_phase = PH_R_LOW;
                        end
                        default: n_phase = r_phase;
                    endcase
                end
            end else if (r_phase != PH_IDLE) begin
                if (tick_count >= {1'b0, phase_len}) begin
                    n_timer = '0;
                    unique case (r_phase) inside
                        PH_RST_LOW: n_phase = PH_RST_WAIT;
                        PH_RST_WAIT: begin
                            n_presence = ~i_item.line_level;
                            if (i_cfg.reset_recovery_us == '0) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_phase = PH_RST_REC;
                            end
                        end
                        PH_RST_REC: begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        PH_W1_LOW: n_phase = PH_W1_REL;
                        PH_W1_REL, PH_W0_LOW: begin
                            if (r_bit == 3'd7) begin
                                n_bit   = 3'd0;
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_bit   = bit_inc;
                                n_phase = r_shift[bit_inc] ? PH_W1_LOW : PH_W0_LOW;
                            end
                        end
                        PH_R_LOW: n_phase = PH_R_SAMPLE;
                        PH_R_SAMPLE: begin
                            if (i_item.line_level) begin
                                n_shift[r_bit] = 1'b1;
                            end
                            n_phase = PH_R_SLOT;
                        end
                        PH_R_SLOT: begin
                            if (r_bit == 3'd7) begin
                                n_rx    = r_shift;
                                n_bit   = 3'd0;
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_bit   = bit_inc;
                                n_phase = PH_R_LOW;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end else begin
                    n_timer = tick_count[REG_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_bit      <= 3'd0;
            r_shift    <= 8'd0;
            r_presence <= 1'b0;
            r_rx       <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_presence <= n_presence;
            r_rx       <= n_rx;
        end
    end

    always_comb begin
        o_res.drive_low      = (n_phase == PH_RST_LOW) || (n_phase == PH_W1_LOW) ||
                               (n_phase == PH_W0_LOW)  || (n_phase == PH_R_LOW);
        o_res.busy_res       = (n_phase != PH_IDLE);
        o_res.done_res       = done;
        o_res.device_present = n_presence;
        o_res.read_byte      = n_rx;
        o_res.refused        = refused;
    end

endmodule

FILE: rtl/one_wire_bus_master.sv
// one-wire bus master top level: one registered result per accepted item
// one item per cycle unless stalled; the result register holds while the sink stalls
// and input ready drops only while a held result has not been taken
// synchronous active-low reset: sequencer idle, status cleared, registers to defaults
// depends on owm_pkg, owm_stream_if, owm_cfg, owm_core
module one_wire_bus_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    owm_stream_if.sink                     i_in,
    owm_stream_if.source                   o_out,
    input  logic                           i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [owm_pkg::REG_W-1:0]      i_cfg_wdata
);
    import owm_pkg::*;

    t_cfg      cfg;
    t_out_item res;
    logic      in_fire;
    logic      in_ready;

    logic      r_out_valid;
    t_out_item r_out_data;

    assign in_ready   = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    owm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    owm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_item  (i_in.data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_ready) begin
            r_out_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

FILE: rtl/owm_checker.sv
// port-level checks on the one-wire bus master, attached by bind
// depends on one_wire_bus_master_assert.svh
`include "one_wire_bus_master_assert.svh"

module owm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_drive_low,
    input logic i_busy,
    input logic i_done,
    input logic i_refused
);

    `OWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `OWM_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `OWM_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, i_out_valid && i_done, !i_busy && !i_refused)
    `OWM_ASSERT_NOW(a_refused_busy, i_clk, i_rst_n, i_out_valid && i_refused, i_busy)
    `OWM_ASSERT_NOW(a_drive_busy, i_clk, i_rst_n, i_out_valid && i_drive_low, i_busy)

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive_low (o_out.data.drive_low),
    .i_busy      (o_out.data.busy_res),
    .i_done      (o_out.data.done_res),
    .i_refused   (o_out.data.refused)
);

FILE: test/tb_one_wire_bus_master.sv
`timescale 1ns / 100ps
// self-checking testbench of the one-wire bus master: directed table, then random command and tick streams
// depends on owm_pkg, owm_stream_if and one_wire_bus_master from the rtl folder
module tb_one_wire_bus_master;
    import owm_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 560;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_REC, SEQ_W1_LOW,
        SEQ_W1_REL, SEQ_W0_LOW, SEQ_R_LOW, SEQ_R_SAMPLE, SEQ_R_SLOT
    } t_seq;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] data;
        logic       line;
        logic [9:0] reps;
        logic       typed;
        t_out_item  want;
    } t_row;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam t_out_item ST_IDLE     = '0;
    localparam t_out_item ST_LOW      = '{drive_low: 1'b1, busy_res: 1'b1, default: '0};
    localparam t_out_item ST_LOW_REF  = '{drive_low: 1'b1, busy_res: 1'b1, refused: 1'b1,
                                          default: '0};
    localparam t_out_item ST_WAIT     = '{busy_res: 1'b1, default: '0};
    localparam t_out_item ST_REC_PRES = '{busy_res: 1'b1, device_present: 1'b1, default: '0};
    localparam t_out_item ST_DONE_PRES = '{done_res: 1'b1, device_present: 1'b1, default: '0};
    localparam t_out_item ST_PRES     = '{device_present: 1'b1, default: '0};

    // first BOOT_ROWS rows run at the reset register values, the rest with every register at zero
    localparam int BOOT_ROWS = 10;
    localparam int NUM_ROWS  = 21;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{MODE_TICK,  8'h00, 1'b1, 10'd1,   TYPED,     ST_IDLE},
        '{MODE_RESET, 8'h00, 1'b0, 10'd1,   TYPED,     ST_LOW},
        '{MODE_WRITE, 8'hFF, 1'b1, 10'd1,   TYPED,     ST_LOW_REF},
        '{MODE_READ,  8'h00, 1'b0, 10'd1,   TYPED,     ST_LOW_REF},
        '{MODE_TICK,  8'h00, 1'b1, 10'd479, TYPED,     ST_LOW},
        '{MODE_TICK,  8'h00, 1'b1, 10'd80,  TYPED,     ST_WAIT},
        '{MODE_TICK,  8'h00, 1'b0, 10'd1,   TYPED,     ST_REC_PRES},
        '{MODE_TICK,  8'h00, 1'b1, 10'd399, TYPED,     ST_REC_PRES},
        '{MODE_TICK,  8'h00, 1'b0, 10'd1,   TYPED,     ST_DONE_PRES},
        '{MODE_TICK,  8'h00, 1'b0, 10'd1,   TYPED,     ST_PRES},
        '{MODE_RESET, 8'h00, 1'b1, 10'd1,   PREDICTED, ST_IDLE},
        '{MODE_TICK,  8'h00, 1'b0, 10'd2,   PREDICTED, ST_IDLE},
        '{MODE_RESET, 8'h00, 1'b1, 10'd1,   PREDICTED, ST_IDLE},
        '{MODE_TICK,  8'h00, 1'b1, 10'd2,   PREDICTED, ST_IDLE},
        '{MODE_WRITE, 8'hFF, 1'b0, 10'd1,   PREDICTED, ST_IDLE},
        '{MODE_TICK,  8'h00, 1'b0, 10'd16,  PREDICTED, ST_IDLE},
        '{MODE_WRITE, 8'h00, 1'b1, 10'd1,   PREDICTED, ST_IDLE},
        '{MODE_TICK,  8'h00, 1'b1, 10'd8,   PREDICTED, ST_IDLE},
        '{MODE_READ,  8'hFF, 1'b0, 10'd1,   PREDICTED, ST_IDLE},
        '{MODE_TICK,  8'h00, 1'b0, 10'd24,  PREDICTED, ST_IDLE},
        '{MODE_TICK,  8'h00, 1'b1, 10'd3,   PREDICTED, ST_IDLE}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0] i_cfg_wdata;

    owm_stream_if #(.T(t_in_item))  item_ch ();
    owm_stream_if #(.T(t_out_item)) status_ch ();

    one_wire_bus_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (item_ch),
        .o_out       (status_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // bus master model state
    t_cfg       cfg;
    t_seq       seq;
    logic [REG_W-1:0] elapsed;
    logic [2:0] bit_pos;
    logic [7:0] shifter;
    logic [7:0] rx_byte;
    logic       present_q;

    t_out_item status_due [$];
    int  useful_items;
    int  mismatches;
    int  idle_cycles;
    int  stall_left;
    logic steady;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int span_of(input t_seq s);
        logic [REG_W-1:0] v;
        case (s)
            SEQ_RST_LOW:  v = cfg.reset_low_us;
            SEQ_RST_WAIT: v = cfg.presence_wait_us;
            SEQ_RST_REC:  v = cfg.reset_recovery_us;
            SEQ_W1_LOW:   v = cfg.write_one_low_us;
            SEQ_W1_REL,
            SEQ_W0_LOW,
            SEQ_R_SLOT:   v = cfg.slot_us;
            SEQ_R_LOW:    v = cfg.read_low_us;
            default:      v = 10'd1;
        endcase
        return (v == 0) ? 1 : int'(v);
    endfunction

    function automatic void enter_seq(input t_seq s);
        seq = s;
        elapsed = '0;
    endfunction

    // returns 1 when the running operation finishes
    function automatic logic seq_advance(input logic line);
        case (seq)
            SEQ_RST_LOW: enter_seq(SEQ_RST_WAIT);
            SEQ_RST_WAIT: begin
                present_q = ~line;
                if (cfg.reset_recovery_us == 0) begin
                    enter_seq(SEQ_IDLE);
                    return 1'b1;
                end
                enter_seq(SEQ_RST_REC);
            end
            SEQ_RST_REC: begin
                enter_seq(SEQ_IDLE);
                return 1'b1;
            end
            SEQ_W1_LOW: enter_seq(SEQ_W1_REL);
            SEQ_W1_REL, SEQ_W0_LOW: begin
                if (bit_pos == 3'd7) begin
                    bit_pos = '0;
                    enter_seq(SEQ_IDLE);
                    return 1'b1;
                end
                bit_pos = bit_pos + 3'd1;
                enter_seq(shifter[bit_pos] ? SEQ_W1_LOW : SEQ_W0_LOW);
            end
            SEQ_R_LOW: enter_seq(SEQ_R_SAMPLE);
            SEQ_R_SAMPLE: begin
                if (line) shifter[bit_pos] = 1'b1;
                enter_seq(SEQ_R_SLOT);
            end
            SEQ_R_SLOT: begin
                if (bit_pos == 3'd7) begin
                    rx_byte = shifter;
                    bit_pos = '0;
                    enter_seq(SEQ_IDLE);
                    return 1'b1;
                end
                bit_pos = bit_pos + 3'd1;
                enter_seq(SEQ_R_LOW);
            end
            default: enter_seq(SEQ_IDLE);
        endcase
        return 1'b0;
    endfunction

    function automatic t_out_item bus_master_step(input t_in_item it);
        t_out_item r;
        int nxt;
        r = '0;
        if (it.mode != MODE_TICK) begin
            if (seq != SEQ_IDLE) begin
                r.refused = 1'b1;
            end else if (it.mode == MODE_RESET) begin
                enter_seq(SEQ_RST_LOW);
            end else if (it.mode == MODE_WRITE) begin
                shifter = it.data_byte;
                bit_pos = '0;
                enter_seq(it.data_byte[0] ? SEQ_W1_LOW : SEQ_W0_LOW);
            end else begin
                shifter = '0;
                bit_pos = '0;
                enter_seq(SEQ_R_LOW);
            end
        end else if (seq != SEQ_IDLE) begin
            nxt = int'(elapsed) + 1;
            if (nxt >= span_of(seq)) r.done_res = seq_advance(it.line_level);
            else elapsed = REG_W'(nxt);
        end
        r.drive_low = seq inside {SEQ_RST_LOW, SEQ_W1_LOW, SEQ_W0_LOW, SEQ_R_LOW};
        r.busy_res = (seq != SEQ_IDLE);
        r.device_present = present_q;
        r.read_byte = rx_byte;
        return r;
    endfunction

    function automatic t_in_item mk_item(input t_mode mode, input logic [7:0] data,
                                         input logic line);
        t_in_item it;
        it.mode = mode;
        it.data_byte = data;
        it.line_level = line;
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [REG_W-1:0] pick_span();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return '0;
        if (r < 7) return REG_W'($urandom_range(1, 3));
        if (r < 9) return REG_W'($urandom_range(4, 12));
        return REG_W'($urandom_range(13, 40));
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        int gap;
        t_out_item pred;
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid = 1'b1;
        item_ch.data = it;
        do @(posedge i_clk); while (!item_ch.ready);
        if ((it.mode == MODE_TICK) == (seq != SEQ_IDLE)) useful_items++;
        pred = bus_master_step(it);
        status_due.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(mk_item(MODE_TICK, 8'($urandom), 1'($urandom)), PREDICTED, ST_IDLE);
    endtask

    // one command, then ticks until the sequencer is idle, with refused commands mixed in
    task automatic run_op(input t_mode mode, input logic [7:0] data);
        send_item(mk_item(mode, data, 1'($urandom)), PREDICTED, ST_IDLE);
        while (seq != SEQ_IDLE) begin
            if ($urandom_range(0, 19) == 0)
                send_item(mk_item(t_mode'($urandom_range(1, 3)), 8'($urandom), 1'($urandom)),
                          PREDICTED, ST_IDLE);
            else
                send_tick();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_RESET_LOW:     cfg.reset_low_us = val;
            CFG_PRESENCE_WAIT: cfg.presence_wait_us = val;
            CFG_RESET_REC:     cfg.reset_recovery_us = val;
            CFG_WRITE_ONE_LOW: cfg.write_one_low_us = val;
            CFG_SLOT:          cfg.slot_us = val;
            CFG_READ_LOW:      cfg.read_low_us = val;
            default: ;
        endcase
    endtask

    // finish the running operation, drain every result, then reprogram
    task automatic apply_settings(input t_cfg c);
        while (seq != SEQ_IDLE) send_tick();
        item_ch.valid = 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_RESET_LOW, c.reset_low_us);
        write_reg(CFG_PRESENCE_WAIT, c.presence_wait_us);
        write_reg(CFG_RESET_REC, c.reset_recovery_us);
        write_reg(CFG_WRITE_ONE_LOW, c.write_one_low_us);
        write_reg(CFG_SLOT, c.slot_us);
        write_reg(CFG_READ_LOW, c.read_low_us);
    endtask

    task automatic match_field(input string fname, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            status_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            status_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && status_ch.valid && status_ch.ready) begin
            if (status_due.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none got %h", $time, status_ch.data);
            end else begin
                want = status_due.pop_front();
                match_field("drive_low", want.drive_low, status_ch.data.drive_low);
                match_field("busy_res", want.busy_res, status_ch.data.busy_res);
                match_field("done_res", want.done_res, status_ch.data.done_res);
                match_field("device_present", want.device_present,
                            status_ch.data.device_present);
                match_field("read_byte", want.read_byte, status_ch.data.read_byte);
                match_field("refused", want.refused, status_ch.data.refused);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (status_ch.valid && status_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL one_wire_bus_master");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int target;
        int quota;
        t_row row;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RESET_LOW;
        i_cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        status_ch.ready = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        mismatches = 0;
        useful_items = 0;
        steady = 1'b0;
        cfg = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_REC_DEF,
                WRITE_ONE_LOW_DEF, SLOT_DEF, READ_LOW_DEF};
        seq = SEQ_IDLE;
        elapsed = '0;
        bit_pos = '0;
        shifter = '0;
        rx_byte = '0;
        present_q = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (i == BOOT_ROWS) apply_settings('0);
            row = DIRECTED_ROWS[i];
            for (int k = 0; k < int'(row.reps); k++)
                send_item(mk_item(row.mode, row.data, row.line), row.typed, row.want);
        end

        target = useful_items + RANDOM_ITEMS;
        while (useful_items < target) begin
            apply_settings('{pick_span(), pick_span(), pick_span(),
                             pick_span(), pick_span(), pick_span()});
            steady = ($urandom_range(0, 3) == 0);
            quota = useful_items + $urandom_range(100, 250);
            while (useful_items < quota) begin
                if ($urandom_range(0, 9) < 7)
                    run_op(t_mode'($urandom_range(1, 3)), 8'($urandom));
                else
                    send_item(mk_item(t_mode'($urandom_range(0, 3)), 8'($urandom),
                                      1'($urandom)), PREDICTED, ST_IDLE);
            end
        end

        steady = 1'b0;
        item_ch.valid = 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("PASS one_wire_bus_master");
        else
            $display("FAIL one_wire_bus_master");
        $finish;
    end
endmodule
